// ===== sv/ofb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ofb_pkg: shared types and constants for the overlap feather blend
// Field widths, configuration register indexes, beat payload structs and the
// stage advance group used between the ramp, the lanes and the top level.
// ----------------------------------------------------------------------------
package ofb_pkg;

  localparam int COLUMN_BITS         = 12;
  localparam int CHAN_BITS           = 8;
  localparam int RECIP_BITS          = 17;
  localparam int CFG_DATA_BITS       = 17;
  localparam int CFG_INDEX_BITS      = 2;
  localparam int WEIGHT_FRAC_DEFAULT = 16;

  localparam logic [COLUMN_BITS-1:0] OVERLAP_START_RESET   = COLUMN_BITS'(0);
  localparam logic [COLUMN_BITS-1:0] OVERLAP_END_RESET     = COLUMN_BITS'(4095);
  localparam logic [RECIP_BITS-1:0]  RAMP_RECIPROCAL_RESET = RECIP_BITS'(16);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_OVERLAP_START   = 2'd0,
    CFG_OVERLAP_END     = 2'd1,
    CFG_RAMP_RECIPROCAL = 2'd2,
    CFG_BLEND_RULE      = 2'd3
  } cfg_index_t;

  typedef enum logic {
    RULE_BLACK_RIGHT = 1'b0,
    RULE_PER_CHANNEL = 1'b1
  } blend_rule_t;

  typedef struct packed {
    logic [COLUMN_BITS-1:0] column;
    logic [CHAN_BITS-1:0]   left_red;
    logic [CHAN_BITS-1:0]   left_green;
    logic [CHAN_BITS-1:0]   left_blue;
    logic [CHAN_BITS-1:0]   right_red;
    logic [CHAN_BITS-1:0]   right_green;
    logic [CHAN_BITS-1:0]   right_blue;
  } pixel_pair_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] out_red;
    logic [CHAN_BITS-1:0] out_green;
    logic [CHAN_BITS-1:0] out_blue;
  } blend_pixel_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } ofb_adv_t;

endpackage
`default_nettype wire

// ===== sv/ofb_ramp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ofb_ramp: column weight ramp
// Two registered stages: region compare with column offset, then the offset
// times the reciprocal. One minus the product, floored at zero, is the Q weight.
// ----------------------------------------------------------------------------
module ofb_ramp import ofb_pkg::*; #(
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_DEFAULT
) (
  input  wire logic                         clk,
  input  wire ofb_adv_t                     adv,
  input  wire logic [COLUMN_BITS-1:0]       column,
  input  wire logic [COLUMN_BITS-1:0]       overlap_start,
  input  wire logic [COLUMN_BITS-1:0]       overlap_end,
  input  wire logic [RECIP_BITS-1:0]        ramp_reciprocal,
  output logic      [WEIGHT_FRAC_BITS:0]    weight,
  output logic                              in_region
);

  localparam int W_W    = WEIGHT_FRAC_BITS + 1;
  localparam int DROP_W = COLUMN_BITS + RECIP_BITS;
  localparam logic [DROP_W-1:0] ONE_D = DROP_W'(1) << WEIGHT_FRAC_BITS;
  localparam logic [W_W-1:0]    ONE_W = W_W'(1) << WEIGHT_FRAC_BITS;

  logic                   before1;
  logic                   past1;
  logic [COLUMN_BITS-1:0] offset1;
  logic                   before2;
  logic                   past2;
  logic [DROP_W-1:0]      drop2;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      before1 <= column < overlap_start;
      past1   <= column >= overlap_end;
      offset1 <= column - overlap_start;
    end
    if (adv.s2) begin
      before2 <= before1;
      past2   <= past1;
      drop2   <= DROP_W'(offset1) * DROP_W'(ramp_reciprocal);
    end
  end

  always_comb begin
    in_region = !before2 && !past2;
    if (before2) begin
      weight = ONE_W;
    end else if (past2) begin
      weight = '0;
    end else if (drop2 >= ONE_D) begin
      weight = '0;
    end else begin
      weight = W_W'(ONE_D - drop2);
    end
  end

endmodule
`default_nettype wire

// ===== sv/ofb_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ofb_lane: one color channel of the blend
// Picks the channel weight from the ramp and the zero tests, then forms
// left*w + right*(1-w) and keeps the truncated integer part.
// ----------------------------------------------------------------------------
module ofb_lane import ofb_pkg::*; #(
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_DEFAULT
) (
  input  wire logic                       clk,
  input  wire ofb_adv_t                   adv,
  input  wire logic [CHAN_BITS-1:0]       left,
  input  wire logic [CHAN_BITS-1:0]       right,
  input  wire blend_rule_t                rule,
  input  wire logic                       right_black,
  input  wire logic                       in_region,
  input  wire logic [WEIGHT_FRAC_BITS:0]  weight,
  output logic      [CHAN_BITS-1:0]       mix
);

  localparam int W_W   = WEIGHT_FRAC_BITS + 1;
  localparam int SUM_W = CHAN_BITS + W_W;
  localparam logic [W_W-1:0] ONE_W = W_W'(1) << WEIGHT_FRAC_BITS;

  logic [W_W-1:0]       w_sel;
  logic [CHAN_BITS-1:0] left3;
  logic [CHAN_BITS-1:0] right3;
  logic [W_W-1:0]       w3;
  logic [SUM_W-1:0]     sum;

  always_comb begin
    w_sel = weight;
    if (in_region) begin
      case (rule)
        RULE_BLACK_RIGHT: begin
          if (right_black) begin
            w_sel = ONE_W;
          end
        end
        RULE_PER_CHANNEL: begin
          if (left == '0) begin
            w_sel = '0;
          end else if (right == '0) begin
            w_sel = ONE_W;
          end
        end
        default: w_sel = weight;
      endcase
    end
  end

  assign sum = SUM_W'(left3) * SUM_W'(w3) + SUM_W'(right3) * SUM_W'(ONE_W - w3);

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      left3  <= left;
      right3 <= right;
      w3     <= w_sel;
    end
    if (adv.s4) begin
      mix <= sum[WEIGHT_FRAC_BITS +: CHAN_BITS];
    end
  end

endmodule
`default_nettype wire

// ===== sv/overlap_feather_blend.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// overlap_feather_blend: linear feather blend of two RGB pixels
// Passes the left pixel before the overlap, the right pixel past it, and a
// fixed point ramp blend inside it, with zero-pixel overrides.
//
//   channel  direction  handshake                 beat
//   pixel    in         pixel_valid/pixel_stall   column, left and right RGB
//   blend    out        blend_valid/blend_stall   stitched RGB
//   cfg      in         cfg_write_en              cfg_index, cfg_data
//
// One beat is taken every clock while pixel_stall is low; a result is offered
// on blend once its beat has passed through every stage named below.
// The four stages are column compare, ramp multiply, weight select, and the
// three channel multipliers that feed the output register.
// Each stage moves when the one after it is empty or moving, so bubbles close.
// Reset clears the stage valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module overlap_feather_blend import ofb_pkg::*; #(
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      pixel_valid,
  output logic                           pixel_stall,
  input  wire pixel_pair_t               pixel,
  output logic                           blend_valid,
  input  wire logic                      blend_stall,
  output blend_pixel_t                   blend,
  input  wire logic                      cfg_write_en,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  logic [COLUMN_BITS-1:0]  overlap_start;
  logic [COLUMN_BITS-1:0]  overlap_end;
  logic [RECIP_BITS-1:0]   ramp_reciprocal;
  blend_rule_t             blend_rule;

  logic                    v1;
  logic                    v2;
  logic                    v3;
  logic                    v4;
  logic                    ready1;
  logic                    ready2;
  logic                    ready3;
  logic                    ready4;
  ofb_adv_t                adv;

  pixel_pair_t             p1;
  pixel_pair_t             p2;
  logic                    right_black;
  logic [WEIGHT_FRAC_BITS:0] weight;
  logic                    in_region;
  logic [CHAN_BITS-1:0]    mix_red;
  logic [CHAN_BITS-1:0]    mix_green;
  logic [CHAN_BITS-1:0]    mix_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      overlap_start   <= OVERLAP_START_RESET;
      overlap_end     <= OVERLAP_END_RESET;
      ramp_reciprocal <= RAMP_RECIPROCAL_RESET;
      blend_rule      <= RULE_BLACK_RIGHT;
    end else if (cfg_write_en) begin
      case (cfg_index_t'(cfg_index))
        CFG_OVERLAP_START:   overlap_start   <= cfg_data[COLUMN_BITS-1:0];
        CFG_OVERLAP_END:     overlap_end     <= cfg_data[COLUMN_BITS-1:0];
        CFG_RAMP_RECIPROCAL: ramp_reciprocal <= cfg_data[RECIP_BITS-1:0];
        CFG_BLEND_RULE:      blend_rule      <= blend_rule_t'(cfg_data[0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    ready4 = !v4 || !blend_stall;
    ready3 = !v3 || ready4;
    ready2 = !v2 || ready3;
    ready1 = !v1 || ready2;
    adv.s1 = ready1;
    adv.s2 = ready2;
    adv.s3 = ready3;
    adv.s4 = ready4;
  end

  assign pixel_stall = !ready1;
  assign blend_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= pixel_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
      if (ready4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      p1 <= pixel;
    end
    if (adv.s2) begin
      p2 <= p1;
    end
  end

  assign right_black = (p2.right_red | p2.right_green | p2.right_blue) == '0;

  ofb_ramp #(
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_ramp (
    .clk             (clk),
    .adv             (adv),
    .column          (pixel.column),
    .overlap_start   (overlap_start),
    .overlap_end     (overlap_end),
    .ramp_reciprocal (ramp_reciprocal),
    .weight          (weight),
    .in_region       (in_region)
  );

  ofb_lane #(
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_lane_red (
    .clk         (clk),
    .adv         (adv),
    .left        (p2.left_red),
    .right       (p2.right_red),
    .rule        (blend_rule),
    .right_black (right_black),
    .in_region   (in_region),
    .weight      (weight),
    .mix         (mix_red)
  );

  ofb_lane #(
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_lane_green (
    .clk         (clk),
    .adv         (adv),
    .left        (p2.left_green),
    .right       (p2.right_green),
    .rule        (blend_rule),
    .right_black (right_black),
    .in_region   (in_region),
    .weight      (weight),
    .mix         (mix_green)
  );

  ofb_lane #(
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_lane_blue (
    .clk         (clk),
    .adv         (adv),
    .left        (p2.left_blue),
    .right       (p2.right_blue),
    .rule        (blend_rule),
    .right_black (right_black),
    .in_region   (in_region),
    .weight      (weight),
    .mix         (mix_blue)
  );

  always_comb begin
    blend.out_red   = mix_red;
    blend.out_green = mix_green;
    blend.out_blue  = mix_blue;
  end

endmodule
`default_nettype wire

// ===== verif/ofb_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ofb_checker: predicts and checks the stitched pixels of the feather blend
// Watches the configuration port and both beat channels. It keeps its own copy
// of the overlap registers and works out the stitched pixel for each accepted
// pixel pair. Each accepted blend beat is compared, field by field, with the
// oldest stitched pixel still awaited.
// ----------------------------------------------------------------------------
module ofb_checker import ofb_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      pixel_valid,
  input  wire logic                      pixel_stall,
  input  wire pixel_pair_t               pixel,
  input  wire logic                      blend_valid,
  input  wire logic                      blend_stall,
  input  wire blend_pixel_t              blend,
  input  wire logic                      cfg_write_en,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  output int                             error_count,
  output int                             pending
);

  localparam int          MAX_REPORTS = 100;
  localparam int unsigned WEIGHT_ONE  = 1 << WEIGHT_FRAC_DEFAULT;

  logic [COLUMN_BITS-1:0] start_col;
  logic [COLUMN_BITS-1:0] end_col;
  logic [RECIP_BITS-1:0]  recip;
  blend_rule_t            rule;

  blend_pixel_t expected_pixels[$];
  int           blend_beats;

  initial begin
    error_count = 0;
    pending     = 0;
    blend_beats = 0;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ofb_checker: %s", msg);
  endtask

  function automatic logic [CHAN_BITS-1:0] mix_channel(
    input logic [CHAN_BITS-1:0] l,
    input logic [CHAN_BITS-1:0] r,
    input int unsigned          w
  );
    int unsigned sum;
    sum = int'(l) * w + int'(r) * (WEIGHT_ONE - w);
    return CHAN_BITS'(sum >> WEIGHT_FRAC_DEFAULT);
  endfunction

  function automatic blend_pixel_t predict_stitched_pixel(input pixel_pair_t p);
    logic [CHAN_BITS-1:0] lc[3];
    logic [CHAN_BITS-1:0] rc[3];
    logic [CHAN_BITS-1:0] oc[3];
    int unsigned          drop;
    int unsigned          ramp;
    int unsigned          w;
    logic                 right_black;
    blend_pixel_t         res;
    lc = '{p.left_red, p.left_green, p.left_blue};
    rc = '{p.right_red, p.right_green, p.right_blue};
    right_black = (p.right_red | p.right_green | p.right_blue) == '0;
    if (p.column < start_col) begin
      oc = lc;
    end else if (p.column >= end_col) begin
      oc = rc;
    end else begin
      drop = (int'(p.column) - int'(start_col)) * int'(recip);
      ramp = (drop >= WEIGHT_ONE) ? 0 : WEIGHT_ONE - drop;
      for (int k = 0; k < 3; k++) begin
        if (rule == RULE_BLACK_RIGHT) begin
          w = right_black ? WEIGHT_ONE : ramp;
        end else if (lc[k] == '0) begin
          w = 0;
        end else if (rc[k] == '0) begin
          w = WEIGHT_ONE;
        end else begin
          w = ramp;
        end
        oc[k] = mix_channel(lc[k], rc[k], w);
      end
    end
    res.out_red   = oc[0];
    res.out_green = oc[1];
    res.out_blue  = oc[2];
    return res;
  endfunction

  always @(posedge clk) begin
    blend_pixel_t want;
    if (rst) begin
      start_col = OVERLAP_START_RESET;
      end_col   = OVERLAP_END_RESET;
      recip     = RAMP_RECIPROCAL_RESET;
      rule      = RULE_BLACK_RIGHT;
      expected_pixels.delete();
    end else begin
      if (cfg_write_en) begin
        case (cfg_index_t'(cfg_index))
          CFG_OVERLAP_START:   start_col = cfg_data[COLUMN_BITS-1:0];
          CFG_OVERLAP_END:     end_col   = cfg_data[COLUMN_BITS-1:0];
          CFG_RAMP_RECIPROCAL: recip     = cfg_data[RECIP_BITS-1:0];
          CFG_BLEND_RULE:      rule      = blend_rule_t'(cfg_data[0]);
          default: ;
        endcase
      end
      if (pixel_valid && !pixel_stall) begin
        expected_pixels.insert(expected_pixels.size(), predict_stitched_pixel(pixel));
      end
      if (blend_valid && !blend_stall) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("blend beat %0d arrived with nothing awaited: %h",
                                    blend_beats, blend));
        end else begin
          want = expected_pixels.pop_front();
          if (blend.out_red !== want.out_red)
            report_mismatch($sformatf("blend beat %0d out_red got %0d expected %0d",
                                      blend_beats, blend.out_red, want.out_red));
          if (blend.out_green !== want.out_green)
            report_mismatch($sformatf("blend beat %0d out_green got %0d expected %0d",
                                      blend_beats, blend.out_green, want.out_green));
          if (blend.out_blue !== want.out_blue)
            report_mismatch($sformatf("blend beat %0d out_blue got %0d expected %0d",
                                      blend_beats, blend.out_blue, want.out_blue));
        end
        blend_beats++;
      end
    end
    pending = expected_pixels.size();
  end

endmodule
`default_nettype wire

// ===== verif/overlap_feather_blend_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// overlap_feather_blend_tb: stimulus and verdict for the feather blend
// Drives pixel pairs through the blend under a series of overlap settings,
// starting with directed beats on the region edges, the empty and inverted
// overlap, zero and steep ramps and both zero rules, then random beats that
// crowd the overlap. The sender and receiver idle and stall at varied rates,
// and one long receiver hold-off backs the pipe up into the sender.
// ----------------------------------------------------------------------------
module overlap_feather_blend_tb;
  import ofb_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 20;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      pixel_valid;
  logic                      pixel_stall;
  pixel_pair_t               pixel;
  logic                      blend_valid;
  logic                      blend_stall;
  blend_pixel_t              blend;
  logic                      cfg_write_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  int                        error_count;
  int                        pending;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  hold_req       = 1'b0;
  int  cur_start      = 0;
  int  cur_end        = 4095;
  int  idle_cycles    = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  overlap_feather_blend u_top (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .blend_valid  (blend_valid),
    .blend_stall  (blend_stall),
    .blend        (blend),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  ofb_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .blend_valid  (blend_valid),
    .blend_stall  (blend_stall),
    .blend        (blend),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .error_count  (error_count),
    .pending      (pending)
  );

  // The receiver stalls at random, or for one long stretch when asked.
  initial begin
    blend_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        blend_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      blend_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (blend_valid && !blend_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("overlap_feather_blend_tb: done, errors");
      $finish;
    end
  end

  function automatic pixel_pair_t make_pair(
    input int col,
    input int lr, input int lg, input int lb,
    input int rr, input int rg, input int rb
  );
    pixel_pair_t p;
    p.column      = COLUMN_BITS'(col);
    p.left_red    = CHAN_BITS'(lr);
    p.left_green  = CHAN_BITS'(lg);
    p.left_blue   = CHAN_BITS'(lb);
    p.right_red   = CHAN_BITS'(rr);
    p.right_green = CHAN_BITS'(rg);
    p.right_blue  = CHAN_BITS'(rb);
    return p;
  endfunction

  function automatic logic [CHAN_BITS-1:0] random_channel();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) return '0;
    if (pick < 25) return '1;
    return CHAN_BITS'($urandom_range(255));
  endfunction

  function automatic pixel_pair_t random_pixel();
    pixel_pair_t p;
    int          lo;
    int          hi;
    lo = (cur_start > 3) ? cur_start - 3 : 0;
    hi = (cur_end < 4092) ? cur_end + 3 : 4095;
    if ($urandom_range(99) < 60 && hi > lo) begin
      p.column = COLUMN_BITS'($urandom_range(hi, lo));
    end else begin
      p.column = COLUMN_BITS'($urandom_range(4095));
    end
    p.left_red    = random_channel();
    p.left_green  = random_channel();
    p.left_blue   = random_channel();
    p.right_red   = random_channel();
    p.right_green = random_channel();
    p.right_blue  = random_channel();
    if ($urandom_range(9) == 0) begin
      p.right_red   = '0;
      p.right_green = '0;
      p.right_blue  = '0;
    end
    return p;
  endfunction

  task automatic send_pixel(input pixel_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    pixel_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input cfg_index_t idx, input int unsigned value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= CFG_DATA_BITS'(value);
    @(posedge clk);
  endtask

  task automatic set_config(
    input int          start_col,
    input int          end_col,
    input int unsigned recip,
    input blend_rule_t rule
  );
    drain_results();
    write_reg(CFG_OVERLAP_START, start_col);
    write_reg(CFG_OVERLAP_END, end_col);
    write_reg(CFG_RAMP_RECIPROCAL, recip);
    write_reg(CFG_BLEND_RULE, rule);
    cfg_write_en <= 1'b0;
    cur_start = start_col;
    cur_end   = end_col;
  endtask

  task automatic run_phase(input int beats, input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (beats) send_pixel(random_pixel());
  endtask

  initial begin
    int          start_col;
    int          width;
    int          end_col;
    int unsigned recip;
    int          mode;
    rst          = 1'b1;
    pixel_valid  = 1'b0;
    pixel        = '0;
    cfg_write_en = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed beats, first under the reset settings.
    send_pixel(make_pair(0, 255, 255, 255, 0, 0, 0));
    send_pixel(make_pair(4095, 0, 0, 0, 255, 255, 255));

    set_config(100, 200, 655, RULE_BLACK_RIGHT);
    send_pixel(make_pair(99, 11, 22, 33, 44, 55, 66));
    send_pixel(make_pair(100, 200, 100, 50, 10, 20, 30));
    send_pixel(make_pair(150, 255, 255, 255, 1, 2, 3));
    send_pixel(make_pair(199, 255, 128, 1, 0, 64, 255));
    send_pixel(make_pair(200, 11, 22, 33, 44, 55, 66));
    send_pixel(make_pair(150, 90, 80, 70, 0, 0, 0));
    send_pixel(make_pair(150, 0, 0, 0, 255, 255, 255));

    set_config(100, 200, 655, RULE_PER_CHANNEL);
    send_pixel(make_pair(150, 0, 10, 20, 30, 0, 40));
    send_pixel(make_pair(150, 0, 0, 0, 0, 0, 0));
    send_pixel(make_pair(120, 255, 255, 255, 255, 255, 255));
    send_pixel(make_pair(180, 1, 128, 254, 254, 127, 1));

    // Empty overlap, then start past end.
    set_config(300, 300, 1000, RULE_BLACK_RIGHT);
    send_pixel(make_pair(299, 5, 6, 7, 8, 9, 10));
    send_pixel(make_pair(300, 5, 6, 7, 8, 9, 10));
    send_pixel(make_pair(301, 5, 6, 7, 8, 9, 10));
    set_config(500, 100, 1000, RULE_PER_CHANNEL);
    send_pixel(make_pair(300, 5, 6, 7, 8, 9, 10));
    send_pixel(make_pair(600, 5, 6, 7, 8, 9, 10));

    // Zero, saturating and full-step ramps.
    set_config(0, 4095, 0, RULE_BLACK_RIGHT);
    send_pixel(make_pair(2000, 100, 150, 200, 50, 60, 70));
    set_config(10, 4000, 131071, RULE_PER_CHANNEL);
    send_pixel(make_pair(10, 100, 150, 200, 50, 60, 70));
    send_pixel(make_pair(11, 100, 150, 200, 50, 60, 70));
    send_pixel(make_pair(4095, 100, 150, 200, 50, 60, 70));
    set_config(0, 4095, 65536, RULE_BLACK_RIGHT);
    send_pixel(make_pair(1, 100, 150, 200, 50, 60, 70));
    send_pixel(make_pair(0, 100, 150, 200, 50, 60, 70));

    // Random beats; the first phase backs the pipe up behind a long stall.
    set_config(1000, 1256, 256, RULE_BLACK_RIGHT);
    hold_req = 1'b1;
    run_phase(60, 0, 0);
    run_phase(120, 0, 0);
    set_config(1000, 1256, 256, RULE_PER_CHANNEL);
    run_phase(120, 74, 0);
    set_config(0, 4095, 16, RULE_PER_CHANNEL);
    run_phase(120, 0, 74);
    set_config(4095, 0, 65536, RULE_BLACK_RIGHT);
    run_phase(80, 25, 25);
    set_config(2000, 2001, 65536, RULE_PER_CHANNEL);
    run_phase(80, 0, 0);
    set_config(10, 4000, 131071, RULE_BLACK_RIGHT);
    run_phase(80, 25, 25);
    set_config(500, 700, 0, RULE_PER_CHANNEL);
    run_phase(80, 74, 0);

    repeat (3) begin
      start_col = $urandom_range(4000);
      width     = $urandom_range(400, 1);
      end_col   = (start_col + width > 4095) ? 4095 : start_col + width;
      recip     = ($urandom_range(9) == 0) ? $urandom_range(131071) : 65536 / width;
      set_config(start_col, end_col, recip, blend_rule_t'($urandom_range(1)));
      mode = $urandom_range(3);
      case (mode)
        0: run_phase(100, 0, 0);
        1: run_phase(100, 74, 0);
        2: run_phase(100, 0, 74);
        default: run_phase(100, 25, 25);
      endcase
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("overlap_feather_blend_tb: done, clean");
    end else begin
      $display("overlap_feather_blend_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
sv/ofb_pkg.sv
sv/ofb_ramp.sv
sv/ofb_lane.sv
sv/overlap_feather_blend.sv
verif/ofb_checker.sv
verif/overlap_feather_blend_tb.sv
